// File: rtl/ble_urc_event_line_parser_top_macros.svh
// Assertion macros shared by the checker.
`ifndef BLE_URC_EVENT_LINE_PARSER_TOP_MACROS_SVH
`define BLE_URC_EVENT_LINE_PARSER_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define BUP_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define BUP_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// File: rtl/bup_pkg.sv
// Shared types and constants of the report line parser.
`timescale 1ns / 1ps
package bup_pkg;
    localparam logic [1:0] KIND_CONN  = 2'd0;
    localparam logic [1:0] KIND_DISC  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [15:0] NO_DESC = 16'hFFFF;
    localparam logic [16:0] NUM_SAT = 17'd65536;

    typedef struct packed {
        logic        ok;
        logic [1:0]  event_kind;
        logic [7:0]  link_number;
        logic [15:0] service_number;
        logic [15:0] char_number;
        logic [15:0] desc_number;
        logic [15:0] payload_offset;
        logic [15:0] payload_length;
    } t_event;

    // Line summary handed from the byte parser to the event builder.
    typedef struct packed {
        logic        failed;
        logic        is_link;
        logic        is_write_val;
        logic        is_tail;
        logic        tail_s2;
        logic        disc;
        logic [16:0] accum;
        logic [8:0]  link_f;
        logic [16:0] srv_f;
        logic [16:0] chr_f;
        logic [16:0] first_f;
        logic [16:0] second_f;
        logic        later_comma;
        logic        second_comma;
        logic [16:0] rem1;
        logic [16:0] rem2;
        logic [15:0] off1;
        logic [15:0] off2;
    } t_summary;

    function automatic logic [16:0] push_digit(input logic [16:0] acc, input logic [7:0] b);
        logic [20:0] v;
        v = {acc, 3'b000} + {2'b00, acc, 1'b0} + {13'd0, (b - 8'h30)};
        return (v > {4'd0, NUM_SAT}) ? NUM_SAT : v[16:0];
    endfunction

    function automatic logic [16:0] inc17(input logic [16:0] v);
        return (v < 17'hFFFF) ? v + 17'd1 : 17'hFFFF;
    endfunction

    function automatic logic [15:0] inc16(input logic [15:0] v);
        return (v != 16'hFFFF) ? v + 16'd1 : 16'hFFFF;
    endfunction
endpackage

// File: rtl/bup_front.sv
// Byte parser: per-byte state update, emits a line summary at line end.
`timescale 1ns / 1ps
module bup_front import bup_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    output logic       o_sum_vld,
    output t_summary   o_sum
);
    typedef enum logic [4:0] {
        PH_PREFIX, PH_LINK_FIRST, PH_LINK_MORE, PH_LINK_DONE,
        PH_WC_FIRST, PH_WC_MORE, PH_WS_FIRST, PH_WS_MORE,
        PH_WH_FIRST, PH_WH_MORE, PH_AFTER_CHR, PH_X_MORE,
        PH_LEN_FIRST, PH_LEN_MORE, PH_VALUE,
        PH_T_S0, PH_T_S1, PH_T_S2, PH_T_SX
    } t_phase;

    t_phase r_ph, n_ph;
    logic [2:0]  r_alive, n_alive;
    logic [15:0] r_pos, n_pos;
    logic [16:0] r_acc, n_acc, r_srv, n_srv, r_chr, n_chr, r_f1, n_f1, r_f2, n_f2;
    logic [8:0]  r_link, n_link;
    logic        r_lc, n_lc, r_sc, n_sc, r_stop, n_stop, r_fail, n_fail;
    logic [16:0] r_rem1, n_rem1, r_rem2, n_rem2;
    logic [15:0] r_off1, n_off1, r_off2, n_off2;

    logic dig, comma, stopb;
    logic [16:0] dval;
    assign dig   = (i_byte >= 8'h30) && (i_byte <= 8'h39);
    assign comma = (i_byte == 8'h2C);
    assign stopb = (i_byte == 8'h0D) || (i_byte == 8'h0A) || (i_byte == 8'h00);
    assign dval  = {9'd0, i_byte - 8'h30};

    function automatic logic [7:0] pfx_char(input logic [1:0] k, input logic [3:0] p);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            2'd0: c = 8'({"+BLECONN:"} >> (8 * (4'd8 - p)));
            2'd1: c = 8'({"+BLEDISCONN:"} >> (8 * (4'd11 - p)));
            default: c = 8'({"+WRITE:"} >> (8 * (4'd6 - p)));
        endcase
        return c;
    endfunction

    localparam logic [3:0] PFX_LEN [3] = '{4'd9, 4'd12, 4'd7};

    always_comb begin
        logic [2:0] alive;
        logic       done;
        n_ph = r_ph; n_alive = r_alive; n_pos = inc16(r_pos); n_acc = r_acc;
        n_link = r_link; n_srv = r_srv; n_chr = r_chr; n_f1 = r_f1; n_f2 = r_f2;
        n_lc = r_lc; n_sc = r_sc; n_rem1 = r_rem1; n_rem2 = r_rem2;
        n_off1 = r_off1; n_off2 = r_off2; n_stop = r_stop; n_fail = r_fail;
        alive = 3'b000;
        done = 1'b0;
        if (!r_fail && !r_stop) begin
            case (r_ph)
                PH_PREFIX: begin
                    for (int k = 0; k < 3; k++) begin
                        if (!done && r_alive[k] && r_pos < {12'd0, PFX_LEN[k]} &&
                            i_byte == pfx_char(2'(k), r_pos[3:0])) begin
                            alive[k] = 1'b1;
                            if (r_pos + 16'd1 == {12'd0, PFX_LEN[k]}) begin
                                done = 1'b1;
                                n_alive = 3'b001 << k;
                                n_ph = (k == 2) ? PH_WC_FIRST : PH_LINK_FIRST;
                            end
                        end
                    end
                    if (!done) begin
                        n_alive = alive;
                        if (alive == 3'b000) n_fail = 1'b1;
                    end
                end
                PH_LINK_FIRST, PH_WC_FIRST, PH_WS_FIRST, PH_WH_FIRST, PH_LEN_FIRST: begin
                    if (dig) begin
                        n_acc = dval;
                        n_ph = t_phase'(r_ph + 5'd1);
                    end else n_fail = 1'b1;
                end
                PH_LINK_MORE: begin
                    if (dig) n_acc = push_digit(r_acc, i_byte);
                    else n_ph = PH_LINK_DONE;
                end
                PH_WC_MORE, PH_WS_MORE, PH_WH_MORE, PH_X_MORE, PH_LEN_MORE: begin
                    if (dig) n_acc = push_digit(r_acc, i_byte);
                    else if (comma) begin
                        case (r_ph)
                            // Anything above 255 keeps bit 8 set.
                            PH_WC_MORE: begin n_link = {|r_acc[16:8], r_acc[7:0]};
                                n_ph = PH_WS_FIRST; end
                            PH_WS_MORE: begin n_srv = r_acc; n_ph = PH_WH_FIRST; end
                            PH_WH_MORE: begin n_chr = r_acc; n_ph = PH_AFTER_CHR; end
                            PH_X_MORE: begin n_f1 = r_acc; n_off1 = inc16(r_pos);
                                n_ph = PH_T_S0; end
                            default: begin n_f2 = r_acc; n_off2 = inc16(r_pos);
                                n_ph = PH_VALUE; end
                        endcase
                    end else n_fail = 1'b1;
                end
                PH_AFTER_CHR: begin
                    if (comma) n_ph = PH_LEN_FIRST;
                    else if (dig) begin n_acc = dval; n_ph = PH_X_MORE; end
                    else n_fail = 1'b1;
                end
                PH_VALUE: begin
                    if (stopb) n_stop = 1'b1;
                    else n_rem2 = inc17(r_rem2);
                end
                PH_T_S0, PH_T_S1, PH_T_S2, PH_T_SX: begin
                    if (stopb) begin
                        n_stop = 1'b1;
                        if (r_ph == PH_T_S0 || r_ph == PH_T_S1) n_ph = PH_T_SX;
                    end else begin
                        n_rem1 = inc17(r_rem1);
                        if (comma) n_lc = 1'b1;
                        case (r_ph)
                            PH_T_S0: begin
                                if (dig) begin n_f2 = dval; n_ph = PH_T_S1; end
                                else n_ph = PH_T_SX;
                            end
                            PH_T_S1: begin
                                if (dig) n_f2 = push_digit(r_f2, i_byte);
                                else if (comma) begin
                                    n_sc = 1'b1; n_off2 = inc16(r_pos); n_ph = PH_T_S2;
                                end else n_ph = PH_T_SX;
                            end
                            PH_T_S2: n_rem2 = inc17(r_rem2);
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
            if (i_byte == 8'h00) n_stop = 1'b1;
        end
    end

    // Summary built from the updated state of the final byte.
    always_comb begin
        o_sum.failed       = n_fail;
        o_sum.is_link      = (n_ph == PH_LINK_MORE) || (n_ph == PH_LINK_DONE);
        o_sum.is_write_val = (n_ph == PH_VALUE);
        o_sum.is_tail      = (n_ph == PH_T_S0) || (n_ph == PH_T_S1) ||
                             (n_ph == PH_T_S2) || (n_ph == PH_T_SX);
        o_sum.tail_s2      = (n_ph == PH_T_S2);
        o_sum.disc         = (n_alive == 3'b010);
        o_sum.accum        = n_acc;
        o_sum.link_f       = n_link;
        o_sum.srv_f        = n_srv;
        o_sum.chr_f        = n_chr;
        o_sum.first_f      = n_f1;
        o_sum.second_f     = n_f2;
        o_sum.later_comma  = n_lc;
        o_sum.second_comma = n_sc;
        o_sum.rem1         = n_rem1;
        o_sum.rem2         = n_rem2;
        o_sum.off1         = n_off1;
        o_sum.off2         = n_off2;
    end
    assign o_sum_vld = i_take && i_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_end)) begin
            r_ph <= PH_PREFIX; r_alive <= 3'b111; r_pos <= '0; r_acc <= '0;
            r_link <= '0; r_srv <= '0; r_chr <= '0; r_f1 <= '0; r_f2 <= '0;
            r_lc <= 1'b0; r_sc <= 1'b0; r_rem1 <= '0; r_rem2 <= '0;
            r_off1 <= '0; r_off2 <= '0; r_stop <= 1'b0; r_fail <= 1'b0;
        end else if (i_take) begin
            r_ph <= n_ph; r_alive <= n_alive; r_pos <= n_pos; r_acc <= n_acc;
            r_link <= n_link; r_srv <= n_srv; r_chr <= n_chr; r_f1 <= n_f1; r_f2 <= n_f2;
            r_lc <= n_lc; r_sc <= n_sc; r_rem1 <= n_rem1; r_rem2 <= n_rem2;
            r_off1 <= n_off1; r_off2 <= n_off2; r_stop <= n_stop; r_fail <= n_fail;
        end
    end
endmodule

// File: rtl/bup_queue.sv
// Two-entry queue of line summaries between parser and event builder.
`timescale 1ns / 1ps
module bup_queue import bup_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_summary i_data,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_empty,
    output t_summary o_data
);
    t_summary r_mem [2];
    logic     r_wp, r_rp;
    logic [1:0] r_cnt;
    logic do_push, do_pop;
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule

// File: rtl/bup_back.sv
// Event builder: turns a line summary into a result and holds it for output.
`timescale 1ns / 1ps
module bup_back import bup_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_q_empty,
    input  t_summary i_sum,
    output logic     o_q_pop,
    input  logic     i_pop,
    output logic     o_empty,
    output t_event   o_ev
);
    t_event ev, r_ev;
    logic   r_vld;
    logic   take;

    always_comb begin
        logic        good;
        logic [16:0] len, rem, desc;
        logic [15:0] off;
        ev = '0;
        ev.desc_number = NO_DESC;
        good = 1'b1; len = '0; rem = '0; off = '0; desc = {1'b0, NO_DESC};
        if (!i_sum.failed) begin
            if (i_sum.is_link) begin
                if (i_sum.accum <= 17'd255) begin
                    ev.ok = 1'b1;
                    ev.event_kind = i_sum.disc ? KIND_DISC : KIND_CONN;
                    ev.link_number = i_sum.accum[7:0];
                end
            end else if (i_sum.is_write_val || i_sum.is_tail) begin
                if (i_sum.is_write_val) begin
                    len = i_sum.second_f; rem = i_sum.rem2; off = i_sum.off2;
                end else if (!i_sum.later_comma) begin
                    len = i_sum.first_f; rem = i_sum.rem1; off = i_sum.off1;
                end else if (i_sum.tail_s2 && i_sum.second_comma) begin
                    desc = i_sum.first_f; len = i_sum.second_f;
                    rem = i_sum.rem2; off = i_sum.off2;
                end else good = 1'b0;
                if (good && i_sum.link_f <= 9'd255 && !i_sum.srv_f[16] &&
                    !i_sum.chr_f[16] && !desc[16] && !len[16] && rem >= len) begin
                    ev.ok = 1'b1;
                    ev.event_kind = KIND_WRITE;
                    ev.link_number = i_sum.link_f[7:0];
                    ev.service_number = i_sum.srv_f[15:0];
                    ev.char_number = i_sum.chr_f[15:0];
                    ev.desc_number = desc[15:0];
                    ev.payload_offset = off;
                    ev.payload_length = len[15:0];
                end
            end
        end
    end

    assign take    = !i_q_empty && (!r_vld || i_pop);
    assign o_q_pop = take;
    assign o_empty = !r_vld;
    assign o_ev    = r_ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= 1'b0;
        else if (take) r_vld <= 1'b1;
        else if (i_pop) r_vld <= 1'b0;
        if (take) r_ev <= ev;
    end
endmodule

// File: rtl/ble_urc_event_line_parser_top.sv
// Top level of the modem report line parser.
//   channel | direction | handshake    | payload
//   line in | in        | push / full  | line_byte, line_end
//   event   | out       | pop / empty  | ok, kind, link, service, char, desc, offset, length
// One byte is taken per cycle while full is low; the byte parser updates its state as each byte is taken.
// A line's summary is written into the queue with its final byte, then moves into the output register once it is free.
// Summaries wait in a two-entry queue; full rises only when queue and output are held.
// Reset is synchronous, active low, and clears the parser, the summary queue and the output valid flag.
`timescale 1ns / 1ps
module ble_urc_event_line_parser_top import bup_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_line_byte,
    input  logic        i_line_end,
    output logic        empty,
    input  logic        pop,
    output logic        o_ok,
    output logic [1:0]  o_event_kind,
    output logic [7:0]  o_link_number,
    output logic [15:0] o_service_number,
    output logic [15:0] o_char_number,
    output logic [15:0] o_desc_number,
    output logic [15:0] o_payload_offset,
    output logic [15:0] o_payload_length
);
    t_summary sum, q_sum;
    logic     sum_vld, q_full, q_empty, q_pop, take;
    t_event   ev;

    // A byte transfer is stalled only while the summary queue is full.
    assign full = q_full;
    assign take = push && !q_full;

    bup_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take), .i_byte(i_line_byte),
        .i_end(i_line_end), .o_sum_vld(sum_vld), .o_sum(sum)
    );

    bup_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(sum_vld), .i_data(sum),
        .o_full(q_full), .i_pop(q_pop), .o_empty(q_empty), .o_data(q_sum)
    );

    bup_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_empty(q_empty), .i_sum(q_sum),
        .o_q_pop(q_pop), .i_pop(pop), .o_empty(empty), .o_ev(ev)
    );

    assign o_ok             = ev.ok;
    assign o_event_kind     = ev.event_kind;
    assign o_link_number    = ev.link_number;
    assign o_service_number = ev.service_number;
    assign o_char_number    = ev.char_number;
    assign o_desc_number    = ev.desc_number;
    assign o_payload_offset = ev.payload_offset;
    assign o_payload_length = ev.payload_length;
endmodule

// File: rtl/bup_checker.sv
// Port-level checker for the line parser, bound to the top level.
`timescale 1ns / 1ps
`include "ble_urc_event_line_parser_top_macros.svh"
module bup_checker import bup_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic        o_ok,
    input logic [1:0]  o_event_kind,
    input logic [15:0] o_desc_number,
    input logic [15:0] o_payload_length
);
    `BUP_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, !empty && !o_ok, o_event_kind == KIND_CONN && o_desc_number == NO_DESC && o_payload_length == 16'd0)
    `BUP_ASSERT_IMP(a_kind_range, i_clk, i_rst_n, !empty, o_event_kind != 2'd3)
    `BUP_ASSERT_NXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty)
    `BUP_ASSERT_IMP(a_full_needs_out, i_clk, i_rst_n, full, !empty)
endmodule

bind ble_urc_event_line_parser_top bup_checker u_bup_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .full(full), .empty(empty), .pop(pop),
    .o_ok(o_ok), .o_event_kind(o_event_kind), .o_desc_number(o_desc_number),
    .o_payload_length(o_payload_length)
);
